FILE: rtl/core/ppu_pkg.sv
// Shared types, constants and step functions of the pinhole projection pipeline.
package ppu_pkg;

    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 34;
    localparam int DIV_LANES  = 3;

    localparam logic ACT_UNPROJECT = 1'b0;
    localparam logic ACT_PROJECT   = 1'b1;

    localparam logic [2:0] REG_FOCAL_X      = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
    localparam logic [2:0] REG_INITIALIZED  = 3'd6;

    localparam logic [33:0] Q_CLAMP = 34'h2_0000_0000;

    typedef struct packed {
        logic [30:0] fx;
        logic [30:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [14:0] width;
        logic [14:0] height;
        logic        init;
    } ppu_cfg_t;

    typedef struct packed {
        logic        action;
        logic        normalize;
        logic        fail;
        logic        xn;
        logic        yn;
        logic [62:0] xm;
        logic [62:0] ym;
        logic [61:0] zz;
        logic [95:0] pu;
        logic [95:0] pv;
        logic [63:0] zmag;
        logic        zzero;
        logic        clamp_u;
        logic        clamp_v;
        logic        un;
        logic        vn;
    } ppu_tag_t;

    typedef struct packed {
        logic [64:0]  rem;
        logic [63:0]  root;
        logic [127:0] sh;
    } sqrt_acc_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [33:0] low;
        logic [33:0] quo;
    } div_acc_t;

    function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a);
        logic [65:0] r2;
        logic [65:0] trial;
        sqrt_acc_t   b;
        r2    = {a.rem[63:0], a.sh[127:126]};
        trial = {a.root, 2'b01};
        b.sh  = {a.sh[125:0], 2'b00};
        if (r2 >= trial) begin
            b.rem  = 65'(r2 - trial);
            b.root = {a.root[62:0], 1'b1};
        end else begin
            b.rem  = r2[64:0];
            b.root = {a.root[62:0], 1'b0};
        end
        return b;
    endfunction

    function automatic div_acc_t div_step(input div_acc_t a, input logic [63:0] d);
        logic [64:0] r2;
        div_acc_t    b;
        r2    = {a.rem, a.low[33]};
        b.low = {a.low[32:0], 1'b0};
        if (r2 >= {1'b0, d}) begin
            b.rem = 64'(r2 - {1'b0, d});
            b.quo = {a.quo[32:0], 1'b1};
        end else begin
            b.rem = r2[63:0];
            b.quo = {a.quo[32:0], 1'b0};
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/ppu_front.sv
// Front stages: offsets, magnitudes, products, clamp test and sum of squares.
module ppu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppu_pkg::ppu_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_action,
    input  logic                in_normalize,
    input  logic signed [31:0]  in_pt_u,
    input  logic signed [31:0]  in_pt_v,
    input  logic signed [63:0]  in_ray_x,
    input  logic signed [63:0]  in_ray_y,
    input  logic signed [63:0]  in_ray_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [127:0]        out_sum,
    output ppu_pkg::ppu_tag_t   out_tag
);

    localparam int NST = 5;

    typedef struct packed {
        ppu_pkg::ppu_tag_t tag;
        logic [31:0]       dum;
        logic [31:0]       dvm;
        logic [63:0]       xabs;
        logic [63:0]       yabs;
    } st1_t;

    typedef struct packed {
        ppu_pkg::ppu_tag_t tag;
        logic [62:0]       pxl;
        logic [62:0]       pxh;
        logic [62:0]       pyl;
        logic [62:0]       pyh;
        logic [96:0]       lim;
    } st2_t;

    typedef struct packed {
        ppu_pkg::ppu_tag_t tag;
        logic [61:0]       x11;
        logic [62:0]       x10;
        logic [63:0]       x00;
        logic [61:0]       y11;
        logic [62:0]       y10;
        logic [63:0]       y00;
        logic [59:0]       z11;
        logic [61:0]       z10;
        logic [63:0]       z00;
    } st3_t;

    typedef struct packed {
        ppu_pkg::ppu_tag_t tag;
        logic [127:0]      xsq;
        logic [127:0]      ysq;
        logic [127:0]      zsq;
    } st4_t;

    typedef struct packed {
        ppu_pkg::ppu_tag_t tag;
        logic [127:0]      sum;
    } st5_t;

    logic [NST-1:0] v_reg;
    logic [NST:0]   en;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;

    logic [32:0] du;
    logic [32:0] dv;
    logic [95:0] pu;
    logic [95:0] pv;

    assign en[NST] = out_ready;
    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_sum   = st5_reg.sum;
    assign out_tag   = st5_reg.tag;

    always_comb begin
        du = {in_pt_u[31], in_pt_u} - {cfg.cx[31], cfg.cx};
        dv = {in_pt_v[31], in_pt_v} - {cfg.cy[31], cfg.cy};
        st1_next               = '0;
        st1_next.tag.action    = in_action;
        st1_next.tag.normalize = in_normalize;
        st1_next.tag.fail      = !cfg.init ||
            (in_action == ppu_pkg::ACT_UNPROJECT && (cfg.fx == '0 || cfg.fy == '0));
        st1_next.tag.xn        = du[32];
        st1_next.tag.yn        = dv[32];
        st1_next.tag.zmag      = in_ray_z[63] ? (~in_ray_z + 64'd1) : in_ray_z;
        st1_next.tag.zzero     = in_ray_z == '0;
        st1_next.tag.un        = in_ray_x[63] ^ in_ray_z[63];
        st1_next.tag.vn        = in_ray_y[63] ^ in_ray_z[63];
        st1_next.dum           = du[32] ? 32'(~du + 33'd1) : du[31:0];
        st1_next.dvm           = dv[32] ? 32'(~dv + 33'd1) : dv[31:0];
        st1_next.xabs          = in_ray_x[63] ? (~in_ray_x + 64'd1) : in_ray_x;
        st1_next.yabs          = in_ray_y[63] ? (~in_ray_y + 64'd1) : in_ray_y;
    end

    always_comb begin
        st2_next        = '0;
        st2_next.tag    = st1_reg.tag;
        st2_next.tag.xm = 63'(st1_reg.dum) * 63'(cfg.fy);
        st2_next.tag.ym = 63'(st1_reg.dvm) * 63'(cfg.fx);
        st2_next.tag.zz = 62'(cfg.fx) * 62'(cfg.fy);
        st2_next.pxl    = 63'(st1_reg.xabs[31:0]) * 63'(cfg.fx);
        st2_next.pxh    = 63'(st1_reg.xabs[63:32]) * 63'(cfg.fx);
        st2_next.pyl    = 63'(st1_reg.yabs[31:0]) * 63'(cfg.fy);
        st2_next.pyh    = 63'(st1_reg.yabs[63:32]) * 63'(cfg.fy);
        st2_next.lim    = {st1_reg.tag.zmag, 33'd0} + 97'(st1_reg.tag.zmag);
    end

    always_comb begin
        pu                   = {1'b0, st2_reg.pxh, 32'd0} + 96'(st2_reg.pxl);
        pv                   = {1'b0, st2_reg.pyh, 32'd0} + 96'(st2_reg.pyl);
        st3_next             = '0;
        st3_next.tag         = st2_reg.tag;
        st3_next.tag.clamp_u = {1'b0, pu} >= st2_reg.lim;
        st3_next.tag.clamp_v = {1'b0, pv} >= st2_reg.lim;
        st3_next.tag.pu      = st3_next.tag.clamp_u ? '0 : pu;
        st3_next.tag.pv      = st3_next.tag.clamp_v ? '0 : pv;
        st3_next.x11 = 62'(st2_reg.tag.xm[62:32]) * 62'(st2_reg.tag.xm[62:32]);
        st3_next.x10 = 63'(st2_reg.tag.xm[62:32]) * 63'(st2_reg.tag.xm[31:0]);
        st3_next.x00 = 64'(st2_reg.tag.xm[31:0]) * 64'(st2_reg.tag.xm[31:0]);
        st3_next.y11 = 62'(st2_reg.tag.ym[62:32]) * 62'(st2_reg.tag.ym[62:32]);
        st3_next.y10 = 63'(st2_reg.tag.ym[62:32]) * 63'(st2_reg.tag.ym[31:0]);
        st3_next.y00 = 64'(st2_reg.tag.ym[31:0]) * 64'(st2_reg.tag.ym[31:0]);
        st3_next.z11 = 60'(st2_reg.tag.zz[61:32]) * 60'(st2_reg.tag.zz[61:32]);
        st3_next.z10 = 62'(st2_reg.tag.zz[61:32]) * 62'(st2_reg.tag.zz[31:0]);
        st3_next.z00 = 64'(st2_reg.tag.zz[31:0]) * 64'(st2_reg.tag.zz[31:0]);
    end

    always_comb begin
        st4_next     = '0;
        st4_next.tag = st3_reg.tag;
        st4_next.xsq = {2'd0, st3_reg.x11, 64'd0} + {32'd0, st3_reg.x10, 33'd0}
                     + {64'd0, st3_reg.x00};
        st4_next.ysq = {2'd0, st3_reg.y11, 64'd0} + {32'd0, st3_reg.y10, 33'd0}
                     + {64'd0, st3_reg.y00};
        st4_next.zsq = {4'd0, st3_reg.z11, 64'd0} + {33'd0, st3_reg.z10, 33'd0}
                     + {64'd0, st3_reg.z00};
    end

    always_comb begin
        st5_next.tag = st4_reg.tag;
        st5_next.sum = st4_reg.xsq + st4_reg.ysq + st4_reg.zsq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st1_reg <= st1_next;
        end
        if (en[1]) begin
            st2_reg <= st2_next;
        end
        if (en[2]) begin
            st3_reg <= st3_next;
        end
        if (en[3]) begin
            st4_reg <= st4_next;
        end
        if (en[4]) begin
            st5_reg <= st5_next;
        end
    end

endmodule

FILE: rtl/core/ppu_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ppu_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [127:0]      in_sum,
    input  ppu_pkg::ppu_tag_t in_tag,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_root,
    output ppu_pkg::ppu_tag_t out_tag
);

    localparam int N = ppu_pkg::SQRT_STEPS;

    logic [N-1:0]        v_reg;
    logic [N:0]          en;
    ppu_pkg::sqrt_acc_t  acc_reg [N];
    ppu_pkg::ppu_tag_t   tag_reg [N];

    assign en[N]     = out_ready;
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_root  = acc_reg[N-1].root;
    assign out_tag   = tag_reg[N-1];

    for (genvar g = 0; g < N; g++) begin : g_st
        ppu_pkg::sqrt_acc_t acc_in;
        ppu_pkg::ppu_tag_t  tag_in;
        logic               v_in;

        if (g == 0) begin : g_first
            assign acc_in = '{rem: '0, root: '0, sh: in_sum};
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign acc_in = acc_reg[g-1];
            assign tag_in = tag_reg[g-1];
            assign v_in   = v_reg[g-1];
        end

        assign en[g] = !v_reg[g] || en[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en[g]) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[g]) begin
                acc_reg[g] <= ppu_pkg::sqrt_step(acc_in);
                tag_reg[g] <= tag_in;
            end
        end
    end

endmodule

FILE: rtl/core/ppu_div.sv
// Pipelined three-lane restoring divider with a shared divisor.
module ppu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_root,
    input  ppu_pkg::ppu_tag_t in_tag,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [33:0]       out_q0,
    output logic [33:0]       out_q1,
    output logic [33:0]       out_q2,
    output ppu_pkg::ppu_tag_t out_tag
);

    localparam int N = ppu_pkg::DIV_STEPS;
    localparam int L = ppu_pkg::DIV_LANES;

    logic [N-1:0]                v_reg;
    logic [N:0]                  en;
    ppu_pkg::div_acc_t [L-1:0]   acc_reg [N];
    logic [63:0]                 dsr_reg [N];
    ppu_pkg::ppu_tag_t           tag_reg [N];

    logic                        proj;
    logic [95:0]                 num [L];
    logic [63:0]                 dsr0;
    ppu_pkg::div_acc_t [L-1:0]   init_acc;

    always_comb begin
        proj   = in_tag.action == ppu_pkg::ACT_PROJECT;
        dsr0   = proj ? in_tag.zmag : in_root;
        num[0] = proj ? in_tag.pu : {1'b0, in_tag.xm, 32'd0};
        num[1] = proj ? in_tag.pv : {1'b0, in_tag.ym, 32'd0};
        num[2] = proj ? 96'd0 : {2'b00, in_tag.zz, 32'd0};
        for (int l = 0; l < L; l++) begin
            init_acc[l].rem = {2'b00, num[l][95:34]};
            init_acc[l].low = num[l][33:0];
            init_acc[l].quo = '0;
        end
    end

    assign en[N]     = out_ready;
    assign in_ready  = en[0];
    assign out_valid = v_reg[N-1];
    assign out_q0    = acc_reg[N-1][0].quo;
    assign out_q1    = acc_reg[N-1][1].quo;
    assign out_q2    = acc_reg[N-1][2].quo;
    assign out_tag   = tag_reg[N-1];

    for (genvar g = 0; g < N; g++) begin : g_st
        ppu_pkg::div_acc_t [L-1:0] acc_in;
        ppu_pkg::div_acc_t [L-1:0] acc_out;
        logic [63:0]               dsr_in;
        ppu_pkg::ppu_tag_t         tag_in;
        logic                      v_in;

        if (g == 0) begin : g_first
            assign acc_in = init_acc;
            assign dsr_in = dsr0;
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign acc_in = acc_reg[g-1];
            assign dsr_in = dsr_reg[g-1];
            assign tag_in = tag_reg[g-1];
            assign v_in   = v_reg[g-1];
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            assign acc_out[l] = ppu_pkg::div_step(acc_in[l], dsr_in);
        end

        assign en[g] = !v_reg[g] || en[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en[g]) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[g]) begin
                acc_reg[g] <= acc_out;
                dsr_reg[g] <= dsr_in;
                tag_reg[g] <= tag_in;
            end
        end
    end

endmodule

FILE: rtl/core/ppu_back.sv
// Back stages: sign, offset, saturation, inside test and output register.
module ppu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppu_pkg::ppu_cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [33:0]        in_q0,
    input  logic [33:0]        in_q1,
    input  logic [33:0]        in_q2,
    input  ppu_pkg::ppu_tag_t  in_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_ok,
    output logic signed [63:0] out_ray_x,
    output logic signed [63:0] out_ray_y,
    output logic signed [63:0] out_ray_z,
    output logic signed [31:0] out_u,
    output logic signed [31:0] out_v
);

    typedef struct packed {
        logic        action;
        logic        fail;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] rz;
        logic [31:0] u;
        logic [31:0] v;
        logic        sat_u;
        logic        sat_v;
    } b1_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] rz;
        logic [31:0] u;
        logic [31:0] v;
    } b2_t;

    logic [1:0] v_reg;
    logic [2:0] en;
    b1_t        b1_reg, b1_next;
    b2_t        b2_reg, b2_next;

    logic [63:0] mx, my;
    logic [33:0] qu, qv;
    logic [34:0] squ, sqv, su, sv;
    logic        in_u, in_v;

    assign en[2]     = out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];
    assign out_ok    = b2_reg.ok;
    assign out_ray_x = b2_reg.rx;
    assign out_ray_y = b2_reg.ry;
    assign out_ray_z = b2_reg.rz;
    assign out_u     = b2_reg.u;
    assign out_v     = b2_reg.v;

    always_comb begin
        mx  = in_tag.normalize ? {30'd0, in_q0} : {1'b0, in_tag.xm};
        my  = in_tag.normalize ? {30'd0, in_q1} : {1'b0, in_tag.ym};
        qu  = in_tag.clamp_u ? ppu_pkg::Q_CLAMP : in_q0;
        qv  = in_tag.clamp_v ? ppu_pkg::Q_CLAMP : in_q1;
        squ = in_tag.un ? (~{1'b0, qu} + 35'd1) : {1'b0, qu};
        sqv = in_tag.vn ? (~{1'b0, qv} + 35'd1) : {1'b0, qv};
        su  = {{3{cfg.cx[31]}}, cfg.cx} + (in_tag.zzero ? 35'd0 : squ);
        sv  = {{3{cfg.cy[31]}}, cfg.cy} + (in_tag.zzero ? 35'd0 : sqv);

        b1_next.action = in_tag.action;
        b1_next.fail   = in_tag.fail;
        b1_next.rx     = in_tag.xn ? (~mx + 64'd1) : mx;
        b1_next.ry     = in_tag.yn ? (~my + 64'd1) : my;
        b1_next.rz     = in_tag.normalize ? {30'd0, in_q2} : {2'b00, in_tag.zz};
        b1_next.sat_u  = su[34:31] != 4'b0000 && su[34:31] != 4'b1111;
        b1_next.sat_v  = sv[34:31] != 4'b0000 && sv[34:31] != 4'b1111;
        b1_next.u      = b1_next.sat_u ? (su[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : su[31:0];
        b1_next.v      = b1_next.sat_v ? (sv[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sv[31:0];
    end

    always_comb begin
        in_u    = !b1_reg.u[31] && (b1_reg.u[30:0] < {cfg.width, 16'd0});
        in_v    = !b1_reg.v[31] && (b1_reg.v[30:0] < {cfg.height, 16'd0});
        b2_next = '0;
        if (!b1_reg.fail) begin
            if (b1_reg.action == ppu_pkg::ACT_UNPROJECT) begin
                b2_next.ok = 1'b1;
                b2_next.rx = b1_reg.rx;
                b2_next.ry = b1_reg.ry;
                b2_next.rz = b1_reg.rz;
            end else begin
                b2_next.ok = !b1_reg.sat_u && !b1_reg.sat_v && in_u && in_v;
                b2_next.u  = b1_reg.u;
                b2_next.v  = b1_reg.v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            if (en[1]) begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            b1_reg <= b1_next;
        end
        if (en[1]) begin
            b2_reg <= b2_next;
        end
    end

endmodule

FILE: rtl/core/pinhole_project_unproject_top.sv
// Top level of the pinhole camera project and unproject pipeline.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  action, point, normalize, ray
//  m_       out        m_valid / m_ready  ok, ray, projected point
//  cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// One item per cycle unless m_ready stalls the pipe; 5 front stages, 64 square root
// stages, 34 divider stages, 2 back stages.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall at m_ready holds only the stages that carry items; empty stages
// keep filling, so s_ready stays high until the whole pipe is full.
module pinhole_project_unproject_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [31:0] s_pt_u,
    input  logic signed [31:0] s_pt_v,
    input  logic               s_normalize,
    input  logic signed [63:0] s_in_ray_x,
    input  logic signed [63:0] s_in_ray_y,
    input  logic signed [63:0] s_in_ray_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic signed [63:0] m_out_ray_x,
    output logic signed [63:0] m_out_ray_y,
    output logic signed [63:0] m_out_ray_z,
    output logic signed [31:0] m_out_u,
    output logic signed [31:0] m_out_v
);

    ppu_pkg::ppu_cfg_t cfg_reg;

    logic              fr_valid, fr_ready;
    logic [127:0]      fr_sum;
    ppu_pkg::ppu_tag_t fr_tag;
    logic              sq_valid, sq_ready;
    logic [63:0]       sq_root;
    ppu_pkg::ppu_tag_t sq_tag;
    logic              dv_valid, dv_ready;
    logic [33:0]       dv_q0, dv_q1, dv_q2;
    ppu_pkg::ppu_tag_t dv_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fx     <= '0;
            cfg_reg.fy     <= '0;
            cfg_reg.cx     <= '0;
            cfg_reg.cy     <= '0;
            cfg_reg.width  <= 15'd640;
            cfg_reg.height <= 15'd480;
            cfg_reg.init   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppu_pkg::REG_FOCAL_X:      cfg_reg.fx     <= cfg_data[30:0];
                ppu_pkg::REG_FOCAL_Y:      cfg_reg.fy     <= cfg_data[30:0];
                ppu_pkg::REG_CENTER_X:     cfg_reg.cx     <= cfg_data;
                ppu_pkg::REG_CENTER_Y:     cfg_reg.cy     <= cfg_data;
                ppu_pkg::REG_IMAGE_WIDTH:  cfg_reg.width  <= cfg_data[14:0];
                ppu_pkg::REG_IMAGE_HEIGHT: cfg_reg.height <= cfg_data[14:0];
                ppu_pkg::REG_INITIALIZED:  cfg_reg.init   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ppu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_action    (s_action),
        .in_normalize (s_normalize),
        .in_pt_u      (s_pt_u),
        .in_pt_v      (s_pt_v),
        .in_ray_x     (s_in_ray_x),
        .in_ray_y     (s_in_ray_y),
        .in_ray_z     (s_in_ray_z),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_sum      (fr_sum),
        .out_tag      (fr_tag)
    );

    ppu_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_sum    (fr_sum),
        .in_tag    (fr_tag),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    ppu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_root   (sq_root),
        .in_tag    (sq_tag),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_q0    (dv_q0),
        .out_q1    (dv_q1),
        .out_q2    (dv_q2),
        .out_tag   (dv_tag)
    );

    ppu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_q0     (dv_q0),
        .in_q1     (dv_q1),
        .in_q2     (dv_q2),
        .in_tag    (dv_tag),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_ok    (m_ok),
        .out_ray_x (m_out_ray_x),
        .out_ray_y (m_out_ray_y),
        .out_ray_z (m_out_ray_z),
        .out_u     (m_out_u),
        .out_v     (m_out_v)
    );

endmodule

FILE: tb/tb_pinhole_project_unproject_top.sv
// Self-checking testbench for the pinhole camera project and unproject pipeline.
`timescale 1ns / 1ps

module tb_pinhole_project_unproject_top;
    import ppu_pkg::*;

    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int IDLE_LIMIT   = 4000;

    typedef struct {
        logic               action;
        logic signed [31:0] pt_u;
        logic signed [31:0] pt_v;
        logic               normalize;
        logic [63:0]        ray_x;
        logic [63:0]        ray_y;
        logic [63:0]        ray_z;
    } cam_item_t;

    typedef struct {
        logic        ok;
        logic [63:0] ray_x;
        logic [63:0] ray_y;
        logic [63:0] ray_z;
        logic [31:0] u;
        logic [31:0] v;
    } cam_result_t;

    typedef struct {
        logic [30:0] fx;
        logic [30:0] fy;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [14:0] width;
        logic [14:0] height;
        logic        init;
    } cam_setup_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = REG_FOCAL_X;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACT_UNPROJECT;
    logic signed [31:0] s_pt_u = '0;
    logic signed [31:0] s_pt_v = '0;
    logic               s_normalize = 1'b0;
    logic signed [63:0] s_in_ray_x = '0;
    logic signed [63:0] s_in_ray_y = '0;
    logic signed [63:0] s_in_ray_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok;
    logic signed [63:0] m_out_ray_x;
    logic signed [63:0] m_out_ray_y;
    logic signed [63:0] m_out_ray_z;
    logic signed [31:0] m_out_u;
    logic signed [31:0] m_out_v;

    cam_setup_t  cam;
    cam_item_t   pending_items[$];
    cam_item_t   held_item;
    cam_result_t expected_results[$];
    int          error_count = 0;
    int          send_idle_pct = 18;
    int          recv_idle_pct = 51;
    logic        stall_go = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    pinhole_project_unproject_top DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [31:0] project_axis(input logic [63:0] ray, input logic [63:0] z,
                                                 input logic [30:0] f, input logic [31:0] c,
                                                 output logic sat);
        logic [63:0]  ray_mag;
        logic [63:0]  z_mag;
        logic [127:0] quo;
        longint       qs;
        longint       pos;
        pos = longint'($signed(c));
        sat = 1'b0;
        if (z != 0) begin
            ray_mag = ray[63] ? -ray : ray;
            z_mag   = z[63] ? -z : z;
            quo     = ({64'b0, ray_mag} * {97'b0, f}) / {64'b0, z_mag};
            qs      = (quo > 128'h2_0000_0000) ? 64'h2_0000_0000 : quo[63:0];
            if (ray[63] != z[63])
                qs = -qs;
            pos += qs;
        end
        if (pos > 64'sd2147483647) begin
            pos = 64'sd2147483647;
            sat = 1'b1;
        end
        if (pos < -64'sd2147483648) begin
            pos = -64'sd2147483648;
            sat = 1'b1;
        end
        return pos[31:0];
    endfunction

    function automatic logic in_image(input logic [31:0] coord, input logic [14:0] size);
        longint pos;
        pos = longint'($signed(coord));
        return pos >= 0 && pos < (longint'(size) << 16);
    endfunction

    function automatic cam_result_t camera_predict(input cam_item_t it);
        cam_result_t  r;
        longint       du;
        longint       dv;
        logic         xn;
        logic         yn;
        logic [63:0]  xm;
        logic [63:0]  ym;
        logic [63:0]  zz;
        logic [127:0] sq;
        logic [127:0] tmp;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic         su;
        logic         sv;
        r = '{default: '0};
        if (!cam.init)
            return r;
        if (it.action == ACT_UNPROJECT) begin
            if (cam.fx == 0 || cam.fy == 0)
                return r;
            du = longint'(it.pt_u) - longint'($signed(cam.cx));
            dv = longint'(it.pt_v) - longint'($signed(cam.cy));
            xn = du < 0;
            yn = dv < 0;
            xm = xn ? -du : du;
            ym = yn ? -dv : dv;
            xm = xm * {33'b0, cam.fy};
            ym = ym * {33'b0, cam.fx};
            zz = {33'b0, cam.fx} * {33'b0, cam.fy};
            r.ok = 1'b1;
            if (it.normalize) begin
                sq = {64'b0, xm} * {64'b0, xm} + {64'b0, ym} * {64'b0, ym}
                   + {64'b0, zz} * {64'b0, zz};
                root = '0;
                for (int b = 63; b >= 0; b--) begin
                    cand = root | (64'b1 << b);
                    if ({64'b0, cand} * {64'b0, cand} <= sq)
                        root = cand;
                end
                if (root == 0) begin
                    r.ok = 1'b0;
                end else begin
                    tmp = {32'b0, xm, 32'b0} / {64'b0, root};
                    xm  = tmp[63:0];
                    tmp = {32'b0, ym, 32'b0} / {64'b0, root};
                    ym  = tmp[63:0];
                    tmp = {32'b0, zz, 32'b0} / {64'b0, root};
                    zz  = tmp[63:0];
                end
            end
            r.ray_x = xn ? -xm : xm;
            r.ray_y = yn ? -ym : ym;
            r.ray_z = zz;
        end else begin
            r.u  = project_axis(it.ray_x, it.ray_z, cam.fx, cam.cx, su);
            r.v  = project_axis(it.ray_y, it.ray_z, cam.fy, cam.cy, sv);
            r.ok = !su && !sv && in_image(r.u, cam.width) && in_image(r.v, cam.height);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    endtask

    // Driver and acceptance-time prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(camera_predict(held_item));
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_item = pending_items.pop_front();
                    s_action    <= held_item.action;
                    s_pt_u      <= held_item.pt_u;
                    s_pt_v      <= held_item.pt_v;
                    s_normalize <= held_item.normalize;
                    s_in_ray_x  <= held_item.ray_x;
                    s_in_ray_y  <= held_item.ray_y;
                    s_in_ray_z  <= held_item.ray_z;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure, including the long hold
    always @(posedge aclk) begin
        if (stall_go)
            stall_left <= STALL_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        m_ready <= aresetn && !stall_go && stall_left <= 1
                   && $urandom_range(99) >= recv_idle_pct;
    end

    // Monitor
    always @(posedge aclk) begin
        cam_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item", $realtime);
            end else begin
                want = expected_results.pop_front();
                if (m_ok !== want.ok)
                    report_mismatch("ok", 64'(m_ok), 64'(want.ok));
                if (m_out_ray_x !== want.ray_x)
                    report_mismatch("out_ray_x", m_out_ray_x, want.ray_x);
                if (m_out_ray_y !== want.ray_y)
                    report_mismatch("out_ray_y", m_out_ray_y, want.ray_y);
                if (m_out_ray_z !== want.ray_z)
                    report_mismatch("out_ray_z", m_out_ray_z, want.ray_z);
                if (m_out_u !== want.u)
                    report_mismatch("out_u", 64'(m_out_u), 64'(want.u));
                if (m_out_v !== want.v)
                    report_mismatch("out_v", 64'(m_out_v), 64'(want.v));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FOCAL_X:      cam.fx = data[30:0];
            REG_FOCAL_Y:      cam.fy = data[30:0];
            REG_CENTER_X:     cam.cx = data;
            REG_CENTER_Y:     cam.cy = data;
            REG_IMAGE_WIDTH:  cam.width = data[14:0];
            REG_IMAGE_HEIGHT: cam.height = data[14:0];
            REG_INITIALIZED:  cam.init = data[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup_camera(input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] init);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_INITIALIZED, init);
    endtask

    task automatic drain_pipe();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(2000)) - 1000) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic cam_item_t raw_item();
        cam_item_t it;
        it.action    = $urandom_range(1);
        it.pt_u      = pick32();
        it.pt_v      = pick32();
        it.normalize = $urandom_range(1);
        it.ray_x     = {$urandom, $urandom};
        it.ray_y     = {$urandom, $urandom};
        it.ray_z     = $urandom_range(3) == 0 ? 64'd0 : {$urandom, $urandom};
        return it;
    endfunction

    // Ray near the optical axis, so the pixel often lands inside the image
    function automatic cam_item_t camera_item();
        cam_item_t it;
        longint    zv;
        it = raw_item();
        if (it.action == ACT_PROJECT) begin
            zv = longint'($urandom_range(4000) + 1) << $urandom_range(32, 8);
            if ($urandom_range(3) == 0)
                zv = -zv;
            it.ray_z = zv;
            it.ray_x = (zv >>> 10) * (longint'($urandom_range(2000)) - 1000);
            it.ray_y = (zv >>> 10) * (longint'($urandom_range(2000)) - 1000);
        end else if ($urandom_range(1)) begin
            it.pt_u = $urandom_range(640 << 16);
            it.pt_v = $urandom_range(480 << 16);
        end
        return it;
    endfunction

    task automatic add_item(input logic act, input logic [31:0] u, input logic [31:0] v,
                            input logic nrm, input logic [63:0] x, input logic [63:0] y,
                            input logic [63:0] z);
        pending_items.push_back('{act, u, v, nrm, x, y, z});
    endtask

    task automatic random_phase(input int count);
        repeat (count) begin
            if ($urandom_range(9) < 7)
                pending_items.push_back(camera_item());
            else
                pending_items.push_back(raw_item());
        end
    endtask

    initial begin
        cam = '{fx: 0, fy: 0, cx: 0, cy: 0, width: 640, height: 480, init: 0};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // uninitialized camera: every action fails
        add_item(ACT_UNPROJECT, 32'h0010_0000, 32'h0020_0000, 1'b1, 0, 0, 0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h1_0000_0000, 64'h1_0000_0000, 64'h1_0000_0000);
        drain_pipe();

        // initialized but zero focal length
        write_reg(REG_INITIALIZED, 32'h1);
        add_item(ACT_UNPROJECT, 32'h0010_0000, 32'h0020_0000, 1'b0, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h0010_0000, 32'h0020_0000, 1'b1, 0, 0, 0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h5_0000_0000, 64'h3_0000_0000, 64'h1_0000_0000);
        drain_pipe();

        setup_camera(32'h0200_0000, 32'h0200_0000, 32'h0140_0000, 32'h00F0_0000,
                     32'd640, 32'd480, 32'h1);
        add_item(ACT_UNPROJECT, 32'h0140_0000, 32'h00F0_0000, 1'b1, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h0, 32'h0, 1'b0, 0, 0, 0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h0, 64'h0, 64'h0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h1);
        add_item(ACT_PROJECT, 0, 0, 1'b1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h1_0000_0000, -64'h1_0000_0000,
                 -64'h1_0000_0000);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(ACT_PROJECT, 0, 0, 1'b0, -64'd1, -64'd1, 64'h1_0000_0000);
        drain_pipe();

        // image edges and upper register bits dropped
        setup_camera(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_8001, 32'h0000_7FFF, 32'hFFFF_FFFF);
        add_item(ACT_UNPROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0, 0, 0);
        add_item(ACT_UNPROJECT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0, 0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h0, 64'h0, 64'h0);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h1, 64'h1, 64'h1);
        drain_pipe();
        setup_camera(32'h0001_0000, 32'h0000_0001, 32'h0, 32'h0,
                     32'h0000_8000, 32'd1, 32'h1);
        add_item(ACT_PROJECT, 0, 0, 1'b0, 64'h0, 64'h0, 64'h0);
        add_item(ACT_UNPROJECT, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 0, 0, 0);
        drain_pipe();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 18;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 3)
                0: setup_camera({1'b0, 15'($urandom_range(1500)), 16'($urandom)},
                                {1'b0, 15'($urandom_range(1500)), 16'($urandom)},
                                $urandom_range(640 << 16), $urandom_range(480 << 16),
                                32'd640, 32'd480, 32'h1);
                1: setup_camera($urandom, $urandom, $urandom, $urandom,
                                $urandom_range(32767), $urandom_range(32767), 32'h1);
                default: setup_camera({1'b0, 15'($urandom_range(40)), 16'($urandom)},
                                      {1'b0, 15'($urandom_range(40)), 16'($urandom)},
                                      pick32(), pick32(), $urandom, $urandom,
                                      $urandom_range(7) != 0);
            endcase
            // the long hold needs more items than the pipe holds
            random_phase(ph == 6 ? 140 : 55);
            if (ph == 6) begin
                @(posedge aclk);
                stall_go <= 1'b1;
                @(posedge aclk);
                stall_go <= 1'b0;
            end
            drain_pipe();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
